FILE: rtl/i2cbc_pkg.sv
`timescale 1ns / 1ps
package i2cbc_pkg;

  localparam int unsigned HalfW  = 16;
  localparam int unsigned PulseW = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  localparam logic [HalfW-1:0]  HalfBitReset   = HalfW'(500);
  localparam logic [PulseW-1:0] MaxPulsesReset = PulseW'(9);

  typedef enum logic [0:0] {
    REG_HALF_BIT   = 1'b0,
    REG_MAX_PULSES = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_REL   = 3'd1,
    PH_LOW   = 3'd2,
    PH_HIGH  = 3'd3,
    PH_STOPA = 3'd4,
    PH_STOPB = 3'd5,
    PH_FINAL = 3'd6
  } phase_e;

  typedef struct packed {
    logic start_req;
    logic sda_in;
  } req_t;

  typedef struct packed {
    logic scl_release;
    logic sda_release;
    logic busy_res;
    logic done_res;
  } rsp_t;

  typedef struct packed {
    logic [HalfW-1:0]  half_bit_ticks;
    logic [PulseW-1:0] max_pulses;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [HalfW-1:0]  tick_count;
    logic [PulseW-1:0] pulse_count;
  } seq_state_t;

endpackage

FILE: rtl/i2c_bus_clear_sequencer.sv
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// request   in         in_valid_i / in_ready_o    in_req_i  (req_t)
// result    out        out_valid_o / out_ready_i  out_rsp_o (rsp_t)
// config    in         apb psel/penable/pwrite    paddr, pwdata, prdata
//
// one request per cycle while in_ready_o is high, result from the result register in the cycle after acceptance
// sequence state and result register advance together in one pass of the step logic
// in_ready_o drops only while a result waits and out_ready_i is low
// reset: idle phase, counters zero, no result pending, registers at 500 and 9
module i2c_bus_clear_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  i2cbc_pkg::req_t             in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output i2cbc_pkg::rsp_t             out_rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [i2cbc_pkg::AddrW-1:0] paddr,
  input  logic [i2cbc_pkg::DataW-1:0] pwdata,
  output logic [i2cbc_pkg::DataW-1:0] prdata,
  output logic                        pready
);
  import i2cbc_pkg::*;

  cfg_t       cfg;
  seq_state_t state_q, state_d;
  rsp_t       rsp_d, rsp_q;
  logic       out_valid_q;
  logic       in_fire;

  i2cbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2cbc_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .req_i   (in_req_i),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= PH_IDLE;
      state_q.tick_count  <= '0;
      state_q.pulse_count <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && rsp_d.done_res) |=> (state_q.phase == PH_IDLE))
    else $error("done without return to idle");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(state_q))
    else $error("sequence state moved without a request");

  a_scl_low_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.scl_release) |->
      (out_rsp_o.busy_res && out_rsp_o.sda_release && !out_rsp_o.done_res))
    else $error("scl driven low outside a pulse");

endmodule

FILE: rtl/i2cbc_cfg.sv
`timescale 1ns / 1ps
module i2cbc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [i2cbc_pkg::AddrW-1:0] paddr,
  input  logic [i2cbc_pkg::DataW-1:0] pwdata,
  output logic [i2cbc_pkg::DataW-1:0] prdata,
  output logic                        pready,
  output i2cbc_pkg::cfg_t             cfg_o
);
  import i2cbc_pkg::*;

  logic [HalfW-1:0]  half_q;
  logic [PulseW-1:0] pulses_q;
  reg_idx_e          idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= HalfBitReset;
      pulses_q <= MaxPulsesReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_HALF_BIT:   half_q   <= pwdata[HalfW-1:0];
        REG_MAX_PULSES: pulses_q <= pwdata[PulseW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HALF_BIT:   prdata = DataW'(half_q);
      REG_MAX_PULSES: prdata = DataW'(pulses_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.half_bit_ticks = half_q;
  assign cfg_o.max_pulses     = pulses_q;

endmodule

FILE: rtl/i2cbc_step.sv
`timescale 1ns / 1ps
module i2cbc_step (
  input  i2cbc_pkg::cfg_t       cfg_i,
  input  i2cbc_pkg::seq_state_t state_i,
  input  i2cbc_pkg::req_t       req_i,
  output i2cbc_pkg::seq_state_t state_o,
  output i2cbc_pkg::rsp_t       rsp_o
);
  import i2cbc_pkg::*;

  logic [HalfW-1:0]  half_len;
  phase_e            ph;
  logic [HalfW-1:0]  tc;
  logic [PulseW-1:0] pc;
  logic [HalfW-1:0]  tc_inc;

  assign half_len = (cfg_i.half_bit_ticks == '0) ? HalfW'(1) : cfg_i.half_bit_ticks;

  always_comb begin
    ph = state_i.phase;
    tc = state_i.tick_count;
    pc = state_i.pulse_count;
    rsp_o = '0;

    // phase advance
    if (ph == PH_IDLE) begin
      if (req_i.start_req) begin
        ph = PH_REL;
        tc = '0;
        pc = '0;
      end
    end else if (tc >= half_len) begin
      tc = '0;
      unique case (ph)
        PH_REL, PH_HIGH: begin
          if ((pc < cfg_i.max_pulses) && !req_i.sda_in) begin
            pc = pc + PulseW'(1);
            ph = PH_LOW;
          end else begin
            ph = PH_STOPA;
          end
        end
        PH_LOW:   ph = PH_HIGH;
        PH_STOPA: ph = PH_STOPB;
        PH_STOPB: ph = PH_FINAL;
        default:  ph = PH_IDLE;
      endcase
    end

    tc_inc = tc + HalfW'(1);

    // line drives and status
    if (ph == PH_IDLE) begin
      rsp_o.scl_release = 1'b1;
      rsp_o.sda_release = 1'b1;
    end else begin
      rsp_o.busy_res    = 1'b1;
      rsp_o.scl_release = (ph != PH_LOW);
      rsp_o.sda_release = !((ph == PH_STOPA) || (ph == PH_STOPB));
      tc = tc_inc;
      if ((ph == PH_FINAL) && (tc_inc >= half_len)) begin
        rsp_o.done_res = 1'b1;
        ph = PH_IDLE;
        tc = '0;
      end
    end

    state_o.phase       = ph;
    state_o.tick_count  = tc;
    state_o.pulse_count = pc;
  end

endmodule
